>>> design/sorted_priority_queue_assert.svh
// Assertion macros for the sorted priority queue.
// Included by the top level; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT_IMPLIES(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted_priority_queue: assertion failed");
`define SPQ_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted_priority_queue: assertion failed");
`else
`define SPQ_ASSERT_IMPLIES(label, clock, rst_n, ante, cons)
`define SPQ_ASSERT_NEXT(label, clock, rst_n, ante, cons)
`endif
`endif

>>> design/spq_pkg.sv
// Package of the sorted priority queue: sizes, codes and shared types.
// Used by the interfaces, the cell and the top level.
`default_nettype none

package spq_pkg;

	localparam int DEPTH         = 32;
	localparam int KEY_WIDTH     = 16;
	localparam int PAYLOAD_WIDTH = 32;
	localparam int CNT_W         = $clog2(DEPTH + 1);
	localparam int STATUS_W      = 2;
	localparam int COUNT_OUT_W   = 6;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef logic signed [KEY_WIDTH-1:0] key_t;
	typedef logic [PAYLOAD_WIDTH-1:0]    payload_t;
	typedef logic [CNT_W-1:0]            count_t;

	// Contents of one cell of the chain.
	typedef struct packed {
		logic     valid;
		key_t     key;
		payload_t payload;
	} entry_t;

	// Command broadcast to every cell in a cycle.
	typedef struct packed {
		logic     ins;
		logic     rem;
		key_t     key;
		payload_t payload;
	} cmd_t;

endpackage

`default_nettype wire

>>> design/spq_if.sv
// Request and response channel interfaces of the sorted priority queue.
// Depends on spq_pkg.
`default_nettype none

interface spq_req_if import spq_pkg::*; ();
	logic     valid;
	logic     ready;
	logic     req_type;
	key_t     key;
	payload_t payload;

	modport source (output valid, output req_type, output key, output payload, input ready);
	modport sink (input valid, input req_type, input key, input payload, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [STATUS_W-1:0]    status;
	logic                   head_valid;
	key_t                   head_key;
	payload_t               head_payload;
	logic [COUNT_OUT_W-1:0] entry_count;

	modport source (output valid, output status, output head_valid, output head_key,
		output head_payload, output entry_count, input ready);
	modport sink (input valid, input status, input head_valid, input head_key,
		input head_payload, input entry_count, output ready);
endinterface

`default_nettype wire

>>> design/sorted_priority_queue.sv
// Sorted priority queue built as a chain of entry cells.
// Depends on spq_pkg, spq_if, spq_cell and sorted_priority_queue_assert.svh.
//
// The queue keeps up to DEPTH entries in ascending signed key order, cell 0
// being the head. Each request beat is applied to all cells together:
// every cell compares its key with the broadcast key and either holds, takes
// the new entry, or takes the entry of its left (insert) or right (remove)
// neighbor. An insert lands after all entries with an equal key, so equal
// keys leave in arrival order; a remove deletes the first entry whose key
// matches. One request beat is accepted per cycle, and its response beat is
// offered in the next cycle; the response holds the status, the head entry
// and the entry count after the request. The response sits in one output
// register, and a new request is taken in the same cycle the pending
// response is taken, so a consumer that is always ready sees one request per
// cycle; a stalled consumer stalls the request side. An insert into a full
// queue is dropped with status full, a remove without a match leaves the
// queue unchanged with status not found. With an empty queue the head fields
// read zero. No clearing pass is needed after reset.
`default_nettype none
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue import spq_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	spq_req_if.sink     req,
	spq_rsp_if.source   rsp
);

	entry_t             cell_q [DEPTH];
	logic [DEPTH-1:0]   keep_v;
	logic [DEPTH-1:0]   match_v;
	cmd_t               cmd;
	logic               accept;
	logic               found;
	logic               full;
	status_t            status_nxt;
	status_t            status_q;
	logic               out_valid_q;
	count_t             count_q;

	// The chain is always packed from cell 0, so the last cell tells if it is full.
	assign full   = cell_q[DEPTH-1].valid;
	assign found  = |match_v;
	assign accept = req.valid && req.ready;

	// A new request is taken whenever the output register is free or being emptied.
	assign req.ready = !out_valid_q || rsp.ready;

	always_comb begin
		cmd.key     = req.key;
		cmd.payload = req.payload;
		cmd.ins     = accept && (req.req_type == REQ_INSERT) && !full;
		cmd.rem     = accept && (req.req_type == REQ_REMOVE) && found;
		status_nxt  = ST_DONE;
		unique case (req.req_type)
			REQ_INSERT: if (full) status_nxt = ST_FULL;
			REQ_REMOVE: if (!found) status_nxt = ST_NOT_FOUND;
			default:    status_nxt = ST_DONE;
		endcase
	end

	// The chain of cells. Cell 0 sees a left neighbor that always keeps, so an
	// insert ahead of every stored key lands there; the last cell sees an empty
	// right neighbor, so a remove frees it.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_k;

		if (i == 0) begin : g_first
			assign left_e = '0;
			assign left_k = 1'b1;
		end else begin : g_mid
			assign left_e = cell_q[i-1];
			assign left_k = keep_v[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = cell_q[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left      (left_e),
			.left_keep (left_k),
			.right     (right_e),
			.cur       (cell_q[i]),
			.keep      (keep_v[i]),
			.match     (match_v[i])
		);
	end

	// Entry count and the output register. The head fields come straight from
	// cell 0, which cannot change while a response beat waits to be taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.ins) begin
				count_q <= count_q + count_t'(1);
			end else if (cmd.rem) begin
				count_q <= count_q - count_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.head_valid   = cell_q[0].valid;
	assign rsp.head_key     = cell_q[0].valid ? cell_q[0].key : '0;
	assign rsp.head_payload = cell_q[0].valid ? cell_q[0].payload : '0;
	assign rsp.entry_count  = COUNT_OUT_W'(count_q);

	// The count and the valid run of the chain must agree at both ends.
	`SPQ_ASSERT_IMPLIES(a_full_count, clk, arst_n, 1'b1, (full == (count_q == count_t'(DEPTH))))
	`SPQ_ASSERT_IMPLIES(a_head_count, clk, arst_n, 1'b1, (cell_q[0].valid == (count_q != '0)))
	// A waiting response beat must hold off new requests.
	`SPQ_ASSERT_IMPLIES(a_stall, clk, arst_n, (out_valid_q && !rsp.ready), (!req.ready))
	// A successful insert adds exactly one entry.
	`SPQ_ASSERT_NEXT(a_ins_count, clk, arst_n, cmd.ins, (count_q == $past(count_q) + count_t'(1)))

endmodule

`default_nettype wire

>>> design/spq_cell.sv
// One cell of the sorted chain: holds one entry and shifts with its neighbors.
// Depends on spq_pkg.
`default_nettype none

module spq_cell import spq_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cmd_t   cmd,
	input  wire entry_t left,
	input  wire logic   left_keep,
	input  wire entry_t right,
	output entry_t      cur,
	output logic        keep,
	output logic        match
);

	logic     valid_q;
	key_t     key_q;
	payload_t payload_q;
	entry_t   nxt;
	logic     shift;

	assign cur   = '{valid: valid_q, key: key_q, payload: payload_q};
	// An entry stays put on insert when its key sorts at or before the new key.
	assign keep  = valid_q && (key_q <= cmd.key);
	assign match = valid_q && (key_q == cmd.key);
	// Sorted order puts every cell from the first match on at a key >= the request.
	assign shift = !valid_q || (key_q >= cmd.key);

	always_comb begin
		nxt = cur;
		if (cmd.ins) begin
			if (!keep) begin
				if (left_keep) begin
					nxt = '{valid: 1'b1, key: cmd.key, payload: cmd.payload};
				end else begin
					nxt = left;
				end
			end
		end else if (cmd.rem && shift) begin
			nxt = right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		key_q     <= nxt.key;
		payload_q <= nxt.payload;
	end

endmodule

`default_nettype wire
